/* hw/rtl/jst_pkg.sv */
// ============================================================================
// jst_pkg: shared types and constants of the JSON structural tokenizer
// Record and level formats, code values and sizes used by all modules.
// ============================================================================
package jst_pkg;

    // Sizes
    localparam int STACK_DEPTH = 256;
    localparam int DEPTH_BITS  = $clog2(STACK_DEPTH);
    localparam int TOKEN_BITS  = 24;
    localparam int REC_MAX     = 4;
    localparam int REC_BITS    = $clog2(REC_MAX);
    localparam int Q_DEPTH     = 4;
    localparam int QP_BITS     = $clog2(Q_DEPTH);

    // Configuration register indexes and reset values
    localparam logic CFG_DEPTH_LIMIT = 1'b0;
    localparam logic CFG_MAX_NUMBER  = 1'b1;
    localparam logic [7:0] RESET_DEPTH_LIMIT = 8'd200;
    localparam logic [5:0] RESET_MAX_NUMBER  = 6'd31;

    // Record kinds
    localparam logic [2:0] REC_NEW   = 3'd0;
    localparam logic [2:0] REC_NEXT  = 3'd1;
    localparam logic [2:0] REC_COUNT = 3'd2;
    localparam logic [2:0] REC_SPAN  = 3'd3;
    localparam logic [2:0] REC_DONE  = 3'd4;

    // Token types
    localparam logic [2:0] TYP_OBJECT = 3'd0;
    localparam logic [2:0] TYP_ARRAY  = 3'd1;
    localparam logic [2:0] TYP_KEY    = 3'd2;
    localparam logic [2:0] TYP_STRING = 3'd3;
    localparam logic [2:0] TYP_NUMBER = 3'd4;
    localparam logic [2:0] TYP_NULL   = 3'd5;
    localparam logic [2:0] TYP_TRUE   = 3'd6;
    localparam logic [2:0] TYP_FALSE  = 3'd7;

    // Parent kinds kept on the stack
    localparam logic [1:0] PAR_OBJECT = 2'd0;
    localparam logic [1:0] PAR_ARRAY  = 2'd1;
    localparam logic [1:0] PAR_KEY    = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_BAD_ROOT    = 4'd1;
    localparam logic [3:0] ERR_DEPTH       = 4'd2;
    localparam logic [3:0] ERR_OBJ_OPEN    = 4'd3;
    localparam logic [3:0] ERR_NO_COLON    = 4'd4;
    localparam logic [3:0] ERR_KEY_VALUE   = 4'd5;
    localparam logic [3:0] ERR_AFTER_KEYV  = 4'd6;
    localparam logic [3:0] ERR_NO_KEY      = 4'd7;
    localparam logic [3:0] ERR_ARR_VALUE   = 4'd8;
    localparam logic [3:0] ERR_AFTER_ARRV  = 4'd9;
    localparam logic [3:0] ERR_NUM_LONG    = 4'd10;
    localparam logic [3:0] ERR_UNTERM      = 4'd11;
    localparam logic [3:0] ERR_BAD_END     = 4'd12;

    // One output record
    typedef struct packed {
        logic [2:0]            kind;
        logic [TOKEN_BITS-1:0] index;
        logic [2:0]            ttype;
        logic [TOKEN_BITS:0]   value;
        logic [31:0]           start;
        logic [31:0]           chars;
        logic [3:0]            err;
    } t_rec;

    // All records caused by one input item
    typedef struct packed {
        logic [REC_BITS:0]        count;
        t_rec [REC_MAX-1:0]       recs;
    } t_bundle;

    // One level of the parent stack
    typedef struct packed {
        logic [1:0]            kind;
        logic [TOKEN_BITS-1:0] index;
        logic [TOKEN_BITS-1:0] count;
    } t_level;

    function automatic t_rec mk_rec(input logic [2:0] kind,
                                    input logic [TOKEN_BITS-1:0] index,
                                    input logic [2:0] ttype,
                                    input logic [TOKEN_BITS:0] value,
                                    input logic [31:0] start,
                                    input logic [31:0] chars,
                                    input logic [3:0] err);
        t_rec r;
        r.kind  = kind;
        r.index = index;
        r.ttype = ttype;
        r.value = value;
        r.start = start;
        r.chars = chars;
        r.err   = err;
        return r;
    endfunction

endpackage

/* hw/rtl/jst_front.sv */
// ============================================================================
// jst_front: byte classifier and parse engine
// Accepts one text byte per cycle unless stalled, runs the parse mode machine
// and parent stack, and hands each byte's records to the queue as one bundle.
// ============================================================================
module jst_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_end_of_text,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output jst_pkg::t_bundle     o_q_data
);

    typedef enum logic [3:0] {
        M_ROOT, M_OBJ_FIRST, M_ARR_FIRST, M_ARR_VALUE, M_KEY_VALUE, M_KEY_STR,
        M_COLON, M_STR, M_NUM, M_SKIP, M_AFTER_VALUE, M_OBJ_NEXT, M_END, M_DONE
    } t_mode;

    localparam int DB = jst_pkg::DEPTH_BITS;
    localparam int TB = jst_pkg::TOKEN_BITS;

    // Parent stack memory: holds every level below the two cached ones.
    jst_pkg::t_level mem [jst_pkg::STACK_DEPTH];
    jst_pkg::t_level r_rd_top, r_rd_below;

    // Registers
    t_mode               r_mode, n_mode;
    logic [DB-1:0]       r_depth, n_depth;
    jst_pkg::t_level     r_top, n_top, r_below, n_below;
    logic                r_top_mem, n_top_mem, r_below_mem, n_below_mem;
    logic [TB-1:0]       r_tok, n_tok, r_keyc, n_keyc, r_strc, n_strc, r_numc, n_numc;
    logic [31:0]         r_key_total, n_key_total, r_str_total, n_str_total;
    logic [31:0]         r_pos, n_pos, r_span, n_span;
    logic                r_parity, n_parity;
    logic [5:0]          r_run, n_run;
    logic                r_pend_en, n_pend_en;
    logic [DB-1:0]       r_pend_addr, n_pend_addr;
    jst_pkg::t_level     r_pend_data, n_pend_data;
    logic [7:0]          r_depth_limit;
    logic [5:0]          r_max_number;

    // Step temporaries
    logic                accept;
    logic                wr_en;
    logic [DB-1:0]       wr_addr;
    jst_pkg::t_level     wr_data;
    jst_pkg::t_rec [jst_pkg::REC_MAX-1:0] recs;
    logic [jst_pkg::REC_BITS:0] cnt;
    logic                key_push, open_req, simple_req, key_req, av_req, push_ok;
    logic [2:0]          open_type;
    logic [1:0]          pops;
    logic [DB:0]         d1;
    logic [TB-1:0]       idx;
    logic [31:0]         len;
    logic [6:0]          run_next;
    jst_pkg::t_level     top_eff, below_eff;
    logic [1:0]          par_kind;

    // Byte classes; the end marker matches none of them
    logic [7:0] b;
    logic c_ws, c_quote, c_lbrace, c_rbrace, c_lbrack, c_rbrack, c_comma, c_colon;
    logic c_bslash, c_n, c_t, c_num_start, c_num_char, c_simple;

    assign b        = i_text_byte;
    assign c_ws     = !i_end_of_text && (b == 8'h20 || b == 8'h09 || b == 8'h0A ||
                                         b == 8'h0D);
    assign c_quote  = !i_end_of_text && b == 8'h22;
    assign c_lbrace = !i_end_of_text && b == 8'h7B;
    assign c_rbrace = !i_end_of_text && b == 8'h7D;
    assign c_lbrack = !i_end_of_text && b == 8'h5B;
    assign c_rbrack = !i_end_of_text && b == 8'h5D;
    assign c_comma  = !i_end_of_text && b == 8'h2C;
    assign c_colon  = !i_end_of_text && b == 8'h3A;
    assign c_bslash = !i_end_of_text && b == 8'h5C;
    assign c_n      = !i_end_of_text && b == 8'h6E;
    assign c_t      = !i_end_of_text && b == 8'h74;
    assign c_num_start = !i_end_of_text && (b == 8'h2D || (b >= 8'h30 && b <= 8'h39));
    assign c_num_char  = c_num_start || (!i_end_of_text &&
                         (b == 8'h2B || b == 8'h2E || b == 8'h65 || b == 8'h45));
    assign c_simple = c_quote || c_num_start || c_n || c_t ||
                      (!i_end_of_text && b == 8'h66);

    // A pending stack write stalls the input, as does a full queue.
    assign o_in_stall = r_pend_en || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    // The cached levels come from the memory read ports right after a pop.
    assign top_eff   = r_top_mem ? r_rd_top : r_top;
    assign below_eff = r_below_mem ? r_rd_below : r_below;

    // Parse step for one byte
    always_comb begin
        n_mode = r_mode; n_depth = r_depth; n_top = top_eff; n_below = below_eff;
        n_top_mem = 1'b0; n_below_mem = 1'b0;
        n_tok = r_tok; n_keyc = r_keyc; n_strc = r_strc; n_numc = r_numc;
        n_key_total = r_key_total; n_str_total = r_str_total;
        n_pos = r_pos; n_span = r_span; n_parity = r_parity; n_run = r_run;
        n_pend_en = 1'b0; n_pend_addr = r_pend_addr; n_pend_data = r_pend_data;
        wr_en = r_pend_en; wr_addr = r_pend_addr; wr_data = r_pend_data;
        recs = '0; cnt = '0; pops = 2'd0;
        key_push = 1'b0; open_req = 1'b0; simple_req = 1'b0; key_req = 1'b0;
        av_req = 1'b0; push_ok = 1'b0; open_type = jst_pkg::TYP_OBJECT;
        d1 = '0; idx = '0; len = '0; run_next = '0; par_kind = '0;

        if (accept && r_mode != M_DONE) begin
            unique case (r_mode)
                M_ROOT: begin
                    if (!c_ws) begin
                        if (c_lbrace || c_lbrack) begin
                            open_req = 1'b1;
                            open_type = c_lbrace ? jst_pkg::TYP_OBJECT : jst_pkg::TYP_ARRAY;
                        end else begin
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                                3'd0, '0, r_pos, '0, jst_pkg::ERR_BAD_ROOT);
                            cnt = cnt + 1'b1;
                            n_mode = M_DONE;
                        end
                    end
                end
                M_OBJ_FIRST, M_OBJ_NEXT: begin
                    if (!c_ws) begin
                        if (c_quote) begin
                            key_req = 1'b1;
                        end else if (c_rbrace && r_mode == M_OBJ_FIRST) begin
                            av_req = 1'b1;
                        end else begin
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                                3'd0, '0, r_pos, '0,
                                (r_mode == M_OBJ_FIRST) ? jst_pkg::ERR_OBJ_OPEN
                                                        : jst_pkg::ERR_NO_KEY);
                            cnt = cnt + 1'b1;
                            n_mode = M_DONE;
                        end
                    end
                end
                M_ARR_FIRST, M_ARR_VALUE: begin
                    if (!c_ws) begin
                        if (c_rbrack && r_mode == M_ARR_FIRST) begin
                            av_req = 1'b1;
                        end else if (c_lbrace || c_lbrack) begin
                            n_top.count = n_top.count + 1'b1;
                            open_req = 1'b1;
                            open_type = c_lbrace ? jst_pkg::TYP_OBJECT : jst_pkg::TYP_ARRAY;
                        end else if (c_simple) begin
                            n_top.count = n_top.count + 1'b1;
                            simple_req = 1'b1;
                        end else begin
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                                3'd0, '0, r_pos, '0, jst_pkg::ERR_ARR_VALUE);
                            cnt = cnt + 1'b1;
                            n_mode = M_DONE;
                        end
                    end
                end
                M_KEY_VALUE: begin
                    if (!c_ws) begin
                        if (c_lbrace || c_lbrack) begin
                            key_push = 1'b1;
                            open_req = 1'b1;
                            open_type = c_lbrace ? jst_pkg::TYP_OBJECT : jst_pkg::TYP_ARRAY;
                        end else if (c_simple) begin
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEXT,
                                r_tok - 1'b1, jst_pkg::TYP_KEY, {1'b0, r_tok} + 2'd2,
                                '0, '0, jst_pkg::ERR_NONE);
                            cnt = cnt + 1'b1;
                            simple_req = 1'b1;
                        end else begin
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                                3'd0, '0, r_pos, '0, jst_pkg::ERR_KEY_VALUE);
                            cnt = cnt + 1'b1;
                            n_mode = M_DONE;
                        end
                    end
                end
                M_KEY_STR, M_STR: begin
                    if (i_end_of_text) begin
                        recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                            3'd0, '0, r_pos, '0, jst_pkg::ERR_UNTERM);
                        cnt = cnt + 1'b1;
                        n_mode = M_DONE;
                    end else if (c_quote && !r_parity) begin
                        len = r_pos - r_span;
                        if (r_mode == M_KEY_STR) begin
                            n_key_total = r_key_total + len;
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_SPAN,
                                r_tok - 1'b1, jst_pkg::TYP_KEY, {1'b0, r_keyc},
                                r_span, len, jst_pkg::ERR_NONE);
                            n_mode = M_COLON;
                        end else begin
                            n_str_total = r_str_total + len;
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_SPAN,
                                r_tok - 1'b1, jst_pkg::TYP_STRING, {1'b0, r_strc},
                                r_span, len, jst_pkg::ERR_NONE);
                            n_mode = M_AFTER_VALUE;
                        end
                        cnt = cnt + 1'b1;
                    end else if (c_bslash) begin
                        n_parity = !r_parity;
                    end else begin
                        n_parity = 1'b0;
                    end
                end
                M_COLON: begin
                    if (!c_ws) begin
                        if (c_colon) begin
                            n_mode = M_KEY_VALUE;
                        end else begin
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                                3'd0, '0, r_pos, '0, jst_pkg::ERR_NO_COLON);
                            cnt = cnt + 1'b1;
                            n_mode = M_DONE;
                        end
                    end
                end
                M_NUM: begin
                    if (c_num_char) begin
                        run_next = {1'b0, r_run} + 1'b1;
                        if (run_next > {1'b0, r_max_number}) begin
                            recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                                3'd0, '0, r_pos, '0, jst_pkg::ERR_NUM_LONG);
                            cnt = cnt + 1'b1;
                            n_mode = M_DONE;
                        end else begin
                            n_run = run_next[5:0];
                        end
                    end else begin
                        recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_SPAN,
                            r_tok - 1'b1, jst_pkg::TYP_NUMBER, {1'b0, r_numc},
                            r_pos - {26'd0, r_run}, {26'd0, r_run}, jst_pkg::ERR_NONE);
                        cnt = cnt + 1'b1;
                        n_mode = M_AFTER_VALUE;
                        av_req = 1'b1;
                    end
                end
                M_SKIP: begin
                    if (i_end_of_text) begin
                        recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                            3'd0, '0, r_pos, '0, jst_pkg::ERR_BAD_END);
                        cnt = cnt + 1'b1;
                        n_mode = M_DONE;
                    end else if (r_run <= 6'd1) begin
                        n_run = '0;
                        n_mode = M_AFTER_VALUE;
                    end else begin
                        n_run = r_run - 1'b1;
                    end
                end
                M_AFTER_VALUE: begin
                    av_req = 1'b1;
                end
                M_END: begin
                    if (!c_ws) begin
                        recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                            3'd0, '0, r_pos, '0,
                            i_end_of_text ? jst_pkg::ERR_NONE : jst_pkg::ERR_BAD_END);
                        cnt = cnt + 1'b1;
                        n_mode = M_DONE;
                    end
                end
                default: begin
                end
            endcase

            // A key that holds a container goes on the stack first.
            if (key_push) begin
                d1 = {1'b0, n_depth} + 1'b1;
                if (d1 > {{(DB-7){1'b0}}, r_depth_limit} || d1 >= (DB+1)'(jst_pkg::STACK_DEPTH))
                begin
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                        3'd0, '0, r_pos, '0, jst_pkg::ERR_DEPTH);
                    cnt = cnt + 1'b1;
                    n_mode = M_DONE;
                    open_req = 1'b0;
                end else begin
                    wr_en = 1'b1; wr_addr = n_depth - 1'b1; wr_data = n_below;
                    n_below = n_top;
                    n_top = '{kind: jst_pkg::PAR_KEY, index: n_tok - 1'b1, count: '0};
                    n_depth = d1[DB-1:0];
                    push_ok = 1'b1;
                end
            end

            // Container token and its stack level
            if (open_req) begin
                idx = n_tok;
                recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEW, idx, open_type, '0,
                    r_pos, '0, jst_pkg::ERR_NONE);
                cnt = cnt + 1'b1;
                n_tok = n_tok + 1'b1;
                d1 = {1'b0, n_depth} + 1'b1;
                if (d1 > {{(DB-7){1'b0}}, r_depth_limit} || d1 >= (DB+1)'(jst_pkg::STACK_DEPTH))
                begin
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                        3'd0, '0, r_pos, '0, jst_pkg::ERR_DEPTH);
                    cnt = cnt + 1'b1;
                    n_mode = M_DONE;
                end else begin
                    if (push_ok) begin
                        n_pend_en = 1'b1; n_pend_addr = n_depth - 1'b1; n_pend_data = n_below;
                    end else begin
                        wr_en = 1'b1; wr_addr = n_depth - 1'b1; wr_data = n_below;
                    end
                    n_below = n_top;
                    n_top = '{kind: open_type[1:0], index: idx, count: '0};
                    n_depth = d1[DB-1:0];
                    n_mode = (open_type == jst_pkg::TYP_OBJECT) ? M_OBJ_FIRST : M_ARR_FIRST;
                end
            end

            // String, number and literal tokens
            if (simple_req) begin
                if (c_quote) begin
                    n_strc = r_strc + 1'b1;
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEW, n_tok,
                        jst_pkg::TYP_STRING, {1'b0, n_strc}, r_pos + 1'b1, r_str_total,
                        jst_pkg::ERR_NONE);
                    n_span = r_pos + 1'b1;
                    n_parity = 1'b0;
                    n_mode = M_STR;
                end else if (c_num_start) begin
                    n_numc = r_numc + 1'b1;
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEW, n_tok,
                        jst_pkg::TYP_NUMBER, {1'b0, n_numc}, r_pos, '0, jst_pkg::ERR_NONE);
                    n_run = 6'd1;
                    n_mode = M_NUM;
                end else if (c_n) begin
                    n_numc = r_numc + 1'b1;
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEW, n_tok,
                        jst_pkg::TYP_NULL, {1'b0, n_numc}, r_pos, '0, jst_pkg::ERR_NONE);
                    n_run = 6'd3;
                    n_mode = M_SKIP;
                end else begin
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEW, n_tok,
                        c_t ? jst_pkg::TYP_TRUE : jst_pkg::TYP_FALSE, '0, r_pos, '0,
                        jst_pkg::ERR_NONE);
                    n_run = c_t ? 6'd3 : 6'd4;
                    n_mode = M_SKIP;
                end
                cnt = cnt + 1'b1;
                n_tok = n_tok + 1'b1;
                // A number limit of zero fails right at the first digit.
                if (c_num_start && r_max_number == 6'd0) begin
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok,
                        3'd0, '0, r_pos, '0, jst_pkg::ERR_NUM_LONG);
                    cnt = cnt + 1'b1;
                    n_mode = M_DONE;
                end
            end

            // Key token
            if (key_req) begin
                n_top.count = n_top.count + 1'b1;
                n_keyc = r_keyc + 1'b1;
                recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEW, n_tok, jst_pkg::TYP_KEY,
                    {1'b0, n_keyc}, r_pos + 1'b1, r_key_total, jst_pkg::ERR_NONE);
                cnt = cnt + 1'b1;
                n_tok = n_tok + 1'b1;
                n_span = r_pos + 1'b1;
                n_parity = 1'b0;
                n_mode = M_KEY_STR;
            end

            // Separator or closer after a value
            if (av_req && !c_ws) begin
                par_kind = n_top.kind;
                if (par_kind == jst_pkg::PAR_KEY && (c_comma || c_rbrace)) begin
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEXT, n_top.index,
                        jst_pkg::TYP_KEY, {1'b0, n_tok} + 1'b1, '0, '0, jst_pkg::ERR_NONE);
                    cnt = cnt + 1'b1;
                    if (n_depth != '0) n_depth = n_depth - 1'b1;
                    n_top = n_below;
                    pops = pops + 1'b1;
                    par_kind = jst_pkg::PAR_OBJECT;
                    if (c_comma) n_mode = M_OBJ_NEXT;
                end else if (c_comma && par_kind == jst_pkg::PAR_OBJECT) begin
                    n_mode = M_OBJ_NEXT;
                end else if (c_comma && par_kind == jst_pkg::PAR_ARRAY) begin
                    n_mode = M_ARR_VALUE;
                end
                if ((c_rbrace && par_kind == jst_pkg::PAR_OBJECT) ||
                    (c_rbrack && par_kind == jst_pkg::PAR_ARRAY)) begin
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_NEXT, n_top.index,
                        {1'b0, n_top.kind}, {1'b0, n_tok} + 1'b1, '0, '0, jst_pkg::ERR_NONE);
                    cnt = cnt + 1'b1;
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_COUNT, n_top.index,
                        {1'b0, n_top.kind}, {1'b0, n_top.count}, '0, '0, jst_pkg::ERR_NONE);
                    cnt = cnt + 1'b1;
                    if (n_depth != '0) n_depth = n_depth - 1'b1;
                    n_top = n_below;
                    pops = pops + 1'b1;
                    n_mode = (n_depth == '0) ? M_END : M_AFTER_VALUE;
                end else if (!c_comma) begin
                    recs[cnt[1:0]] = jst_pkg::mk_rec(jst_pkg::REC_DONE, n_tok, 3'd0, '0,
                        r_pos, '0, (par_kind == jst_pkg::PAR_ARRAY) ? jst_pkg::ERR_AFTER_ARRV
                                                                   : jst_pkg::ERR_AFTER_KEYV);
                    cnt = cnt + 1'b1;
                    n_mode = M_DONE;
                end
            end

            n_top_mem   = (pops == 2'd2);
            n_below_mem = (pops != 2'd0);
            if (!i_end_of_text) n_pos = r_pos + 1'b1;
        end
    end

    assign o_q_push        = accept && cnt != '0;
    assign o_q_data.count  = cnt;
    assign o_q_data.recs   = recs;

    // Stack memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd_top   <= mem[n_depth];
        r_rd_below <= mem[n_depth - 1'b1];
    end

    // Parse state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= M_ROOT;
            r_depth       <= '0;
            r_top_mem     <= 1'b0;
            r_below_mem   <= 1'b0;
            r_tok         <= '0;
            r_keyc        <= '0;
            r_strc        <= '0;
            r_numc        <= '0;
            r_key_total   <= '0;
            r_str_total   <= '0;
            r_pos         <= '0;
            r_span        <= '0;
            r_parity      <= 1'b0;
            r_run         <= '0;
            r_pend_en     <= 1'b0;
            r_depth_limit <= jst_pkg::RESET_DEPTH_LIMIT;
            r_max_number  <= jst_pkg::RESET_MAX_NUMBER;
        end else begin
            r_mode      <= n_mode;
            r_depth     <= n_depth;
            r_top_mem   <= n_top_mem;
            r_below_mem <= n_below_mem;
            r_tok       <= n_tok;
            r_keyc      <= n_keyc;
            r_strc      <= n_strc;
            r_numc      <= n_numc;
            r_key_total <= n_key_total;
            r_str_total <= n_str_total;
            r_pos       <= n_pos;
            r_span      <= n_span;
            r_parity    <= n_parity;
            r_run       <= n_run;
            r_pend_en   <= n_pend_en;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    jst_pkg::CFG_DEPTH_LIMIT: r_depth_limit <= i_cfg_data;
                    jst_pkg::CFG_MAX_NUMBER:  r_max_number  <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Cached stack levels and the deferred write
    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_below     <= n_below;
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
    end

endmodule

/* hw/rtl/jst_queue.sv */
// ============================================================================
// jst_queue: record bundle queue
// Short register queue between the parse engine and the record sender.
// ============================================================================
module jst_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jst_pkg::t_bundle i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output jst_pkg::t_bundle o_data
);

    localparam int PB = jst_pkg::QP_BITS;

    jst_pkg::t_bundle r_slot [jst_pkg::Q_DEPTH];
    logic [PB-1:0]    r_head, r_tail;
    logic [PB:0]      r_fill;

    assign o_full  = r_fill == (PB+1)'(jst_pkg::Q_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_data  = r_slot[r_head];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_tail] <= i_data;
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_tail <= r_tail + 1'b1;
            if (i_pop)  r_head <= r_head + 1'b1;
            r_fill <= r_fill + (PB+1)'(i_push) - (PB+1)'(i_pop);
        end
    end

endmodule

/* hw/rtl/jst_back.sv */
// ============================================================================
// jst_back: record sender
// Takes bundles from the queue and sends their records one per cycle unless
// stalled, via a registered output, marking the final record of each bundle.
// ============================================================================
module jst_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  jst_pkg::t_bundle                    i_q_data,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_record_kind,
    output logic [jst_pkg::TOKEN_BITS-1:0]      o_token_index,
    output logic [2:0]                          o_token_type,
    output logic [jst_pkg::TOKEN_BITS:0]        o_value,
    output logic [31:0]                         o_text_start,
    output logic [31:0]                         o_text_chars,
    output logic [3:0]                          o_error_code,
    output logic                                o_last
);

    logic [jst_pkg::REC_BITS-1:0] r_sub;
    logic                         r_valid;
    jst_pkg::t_rec                r_rec;
    logic                         r_last;
    logic                         load, is_last;

    assign load    = i_q_valid && (!r_valid || !i_out_stall);
    assign is_last = ({1'b0, r_sub} + 1'b1) == i_q_data.count;
    assign o_q_pop = load && is_last;

    // Sequencing through the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sub   <= is_last ? '0 : r_sub + 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec  <= i_q_data.recs[r_sub];
            r_last <= is_last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_record_kind = r_rec.kind;
    assign o_token_index = r_rec.index;
    assign o_token_type  = r_rec.ttype;
    assign o_value       = r_rec.value;
    assign o_text_start  = r_rec.start;
    assign o_text_chars  = r_rec.chars;
    assign o_error_code  = r_rec.err;
    assign o_last        = r_last;

endmodule

/* hw/rtl/json_structural_tokenizer.sv */
// ============================================================================
// json_structural_tokenizer: streaming JSON token table builder
// Parse engine, record queue and record sender.
// ============================================================================
// The block takes one byte of JSON text per cycle unless stalled and reports
// the token table as records, one per cycle unless the receiver stalls. A byte
// that closes containers (up to four records) thus paces the output; a
// four-bundle queue absorbs the difference until it fills.
// Opening a container as the value of a key takes one extra cycle, since both
// new parent levels must be written through the single stack memory port.
// The parent stack needs no clearing after reset.
module json_structural_tokenizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_end_of_text,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_record_kind,
    output logic [jst_pkg::TOKEN_BITS-1:0] o_token_index,
    output logic [2:0]                     o_token_type,
    output logic [jst_pkg::TOKEN_BITS:0]   o_value,
    output logic [31:0]                    o_text_start,
    output logic [31:0]                    o_text_chars,
    output logic [3:0]                     o_error_code,
    output logic                           o_last
);

    logic             q_push, q_full, q_pop, q_valid;
    jst_pkg::t_bundle q_in, q_out;

    // Parse engine
    jst_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_text_byte(i_text_byte), .i_end_of_text(i_end_of_text),
        .i_q_full(q_full), .o_q_push(q_push), .o_q_data(q_in)
    );

    // Bundle queue
    jst_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_data(q_out)
    );

    // Record sender
    jst_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_data(q_out), .o_q_pop(q_pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_record_kind(o_record_kind), .o_token_index(o_token_index),
        .o_token_type(o_token_type), .o_value(o_value),
        .o_text_start(o_text_start), .o_text_chars(o_text_chars),
        .o_error_code(o_error_code), .o_last(o_last)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench of the JSON structural tokenizer
// Feeds one JSON document byte by byte, with random idling on both sides and
// register writes between phases, and checks every record it emits against
// a cycle-free model of the token table.
// ============================================================================
module tb;
    import jst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;

    typedef enum int {
        MD_ROOT, MD_OBJ_FIRST, MD_ARR_FIRST, MD_ARR_VALUE, MD_KEY_VALUE,
        MD_KEY_STR, MD_COLON, MD_STR, MD_NUM, MD_SKIP, MD_AFTER, MD_OBJ_NEXT,
        MD_END, MD_DONE
    } parse_mode_e;

    localparam int END_MARK = 256;

    typedef struct {
        t_rec r;
        bit   fin;
    } token_rec_t;

    typedef struct {
        logic [7:0] b;
        bit         eot;
        bit         brk;
        logic       cidx;
        logic [7:0] cval;
        bit         hold;
    } text_item_t;

    // ------------------------------------------------------------------------
    // Token table scoreboard: tracks the parse and holds the records due.
    // ------------------------------------------------------------------------
    class token_scoreboard;
        parse_mode_e     mode;
        int unsigned     depth, lim_depth, lim_num, run;
        logic [1:0]      pkind[STACK_DEPTH];
        logic [23:0]     pidx[STACK_DEPTH];
        logic [23:0]     pcnt[STACK_DEPTH];
        logic [23:0]     ntok, nkey, nstr, nnum;
        logic [31:0]     kchars, schars, pos, span;
        bit              bsl;
        token_rec_t      step_q[$];
        token_rec_t      due[$];
        int              errors, records;

        function new();
            mode = MD_ROOT;
            depth = 0; run = 0; bsl = 0;
            lim_depth = RESET_DEPTH_LIMIT;
            lim_num = RESET_MAX_NUMBER;
            ntok = 0; nkey = 0; nstr = 0; nnum = 0;
            kchars = 0; schars = 0; pos = 0; span = 0;
            errors = 0; records = 0;
            foreach (pkind[i]) begin
                pkind[i] = 0;
                pidx[i] = 0;
                pcnt[i] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == CFG_DEPTH_LIMIT) lim_depth = val;
            else lim_num = val[5:0];
        endfunction

        function void put(logic [2:0] k, logic [23:0] idx, logic [2:0] t,
                          logic [24:0] v, logic [31:0] s, logic [31:0] c,
                          logic [3:0] e);
            token_rec_t x;
            if (step_q.size() >= REC_MAX) return;
            x.r = mk_rec(k, idx, t, v, s, c, e);
            x.fin = 0;
            step_q.push_back(x);
        endfunction

        function void stop(logic [3:0] e, logic [31:0] p);
            put(REC_DONE, ntok, 0, 0, p, 0, e);
            mode = MD_DONE;
        endfunction

        function int top();
            return depth < STACK_DEPTH ? depth : 0;
        endfunction

        function void tok(logic [2:0] t, logic [23:0] v, logic [31:0] s,
                          logic [31:0] c);
            put(REC_NEW, ntok, t, {1'b0, v}, s, c, ERR_NONE);
            ntok++;
        endfunction

        function bit push_level(logic [1:0] k, logic [23:0] idx, logic [31:0] p);
            int unsigned d;
            d = depth + 1;
            if (d > lim_depth || d >= STACK_DEPTH) begin
                stop(ERR_DEPTH, p);
                return 0;
            end
            depth = d;
            pkind[d] = k;
            pidx[d] = idx;
            pcnt[d] = 0;
            return 1;
        endfunction

        function void open(logic [2:0] t, logic [31:0] p);
            logic [23:0] idx;
            idx = ntok;
            tok(t, 0, p, 0);
            if (push_level(t[1:0], idx, p))
                mode = (t == TYP_OBJECT) ? MD_OBJ_FIRST : MD_ARR_FIRST;
        endfunction

        function void close_top();
            int d;
            d = top();
            put(REC_NEXT, pidx[d], {1'b0, pkind[d]}, {1'b0, ntok} + 25'd1, 0, 0,
                ERR_NONE);
            put(REC_COUNT, pidx[d], {1'b0, pkind[d]}, {1'b0, pcnt[d]}, 0, 0,
                ERR_NONE);
            if (depth > 0) depth--;
            mode = (depth == 0) ? MD_END : MD_AFTER;
        endfunction

        function void close_key();
            int d;
            d = top();
            put(REC_NEXT, pidx[d], TYP_KEY, {1'b0, ntok} + 25'd1, 0, 0, ERR_NONE);
            if (depth > 0) depth--;
        endfunction

        function bit is_ws(int c);
            return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
        endfunction

        function bit num_start(int c);
            return c == "-" || (c >= "0" && c <= "9");
        endfunction

        function bit num_char(int c);
            return num_start(c) || c == "+" || c == "." || c == "e" || c == "E";
        endfunction

        function bit simple_start(int c);
            return c == "\"" || num_start(c) || c == "n" || c == "t" || c == "f";
        endfunction

        function void start_simple(int c, logic [31:0] p);
            if (c == "\"") begin
                nstr++;
                tok(TYP_STRING, nstr, p + 1, schars);
                span = p + 1;
                bsl = 0;
                mode = MD_STR;
            end else if (num_start(c)) begin
                nnum++;
                tok(TYP_NUMBER, nnum, p, 0);
                run = 1;
                if (run > lim_num) stop(ERR_NUM_LONG, p);
                else mode = MD_NUM;
            end else begin
                if (c == "n") begin
                    nnum++;
                    tok(TYP_NULL, nnum, p, 0);
                    run = 3;
                end else if (c == "t") begin
                    tok(TYP_TRUE, 0, p, 0);
                    run = 3;
                end else begin
                    tok(TYP_FALSE, 0, p, 0);
                    run = 4;
                end
                mode = MD_SKIP;
            end
        endfunction

        function void start_key(logic [31:0] p);
            pcnt[top()]++;
            nkey++;
            tok(TYP_KEY, nkey, p + 1, kchars);
            span = p + 1;
            bsl = 0;
            mode = MD_KEY_STR;
        endfunction

        function void array_value(int c, logic [31:0] p);
            if (c == "[" || c == "{") begin
                pcnt[top()]++;
                open(c == "{" ? TYP_OBJECT : TYP_ARRAY, p);
            end else if (simple_start(c)) begin
                pcnt[top()]++;
                start_simple(c, p);
            end else begin
                stop(ERR_ARR_VALUE, p);
            end
        endfunction

        function void key_value(int c, logic [31:0] p);
            if (c == "[" || c == "{") begin
                if (push_level(PAR_KEY, ntok - 24'd1, p))
                    open(c == "{" ? TYP_OBJECT : TYP_ARRAY, p);
            end else if (simple_start(c)) begin
                put(REC_NEXT, ntok - 24'd1, TYP_KEY, {1'b0, ntok} + 25'd2, 0, 0,
                    ERR_NONE);
                start_simple(c, p);
            end else begin
                stop(ERR_KEY_VALUE, p);
            end
        endfunction

        function void after_value(int c, logic [31:0] p);
            logic [1:0] k;
            if (is_ws(c)) return;
            k = pkind[top()];
            if (k == PAR_ARRAY) begin
                if (c == ",") mode = MD_ARR_VALUE;
                else if (c == "]") close_top();
                else stop(ERR_AFTER_ARRV, p);
            end else if (k == PAR_OBJECT) begin
                if (c == ",") mode = MD_OBJ_NEXT;
                else if (c == "}") close_top();
                else stop(ERR_AFTER_KEYV, p);
            end else begin
                if (c == ",") begin
                    close_key();
                    mode = MD_OBJ_NEXT;
                end else if (c == "}") begin
                    close_key();
                    close_top();
                end else begin
                    stop(ERR_AFTER_KEYV, p);
                end
            end
        endfunction

        function void quoted(int c, logic [31:0] p, bit is_key);
            logic [31:0] len;
            if (c == END_MARK) begin
                stop(ERR_UNTERM, p);
                return;
            end
            if (c == "\"" && !bsl) begin
                len = p - span;
                if (is_key) begin
                    kchars += len;
                    put(REC_SPAN, ntok - 24'd1, TYP_KEY, {1'b0, nkey}, span, len,
                        ERR_NONE);
                    mode = MD_COLON;
                end else begin
                    schars += len;
                    put(REC_SPAN, ntok - 24'd1, TYP_STRING, {1'b0, nstr}, span, len,
                        ERR_NONE);
                    mode = MD_AFTER;
                end
            end else if (c == "\\") begin
                bsl = !bsl;
            end else begin
                bsl = 0;
            end
        endfunction

        // Advance the parse by one accepted request and queue its records.
        function void note_input(logic [7:0] b, bit eot);
            int c;
            logic [31:0] p;
            c = eot ? END_MARK : int'(b);
            p = pos;
            if (mode == MD_DONE) return;
            step_q.delete();
            case (mode)
                MD_ROOT: begin
                    if (!is_ws(c)) begin
                        if (c == "{") open(TYP_OBJECT, p);
                        else if (c == "[") open(TYP_ARRAY, p);
                        else stop(ERR_BAD_ROOT, p);
                    end
                end
                MD_OBJ_FIRST: begin
                    if (!is_ws(c)) begin
                        if (c == "\"") start_key(p);
                        else if (c == "}") close_top();
                        else stop(ERR_OBJ_OPEN, p);
                    end
                end
                MD_ARR_FIRST: begin
                    if (!is_ws(c)) begin
                        if (c == "]") close_top();
                        else array_value(c, p);
                    end
                end
                MD_ARR_VALUE: if (!is_ws(c)) array_value(c, p);
                MD_KEY_VALUE: if (!is_ws(c)) key_value(c, p);
                MD_KEY_STR:   quoted(c, p, 1);
                MD_COLON: begin
                    if (!is_ws(c)) begin
                        if (c == ":") mode = MD_KEY_VALUE;
                        else stop(ERR_NO_COLON, p);
                    end
                end
                MD_STR: quoted(c, p, 0);
                MD_NUM: begin
                    if (num_char(c)) begin
                        if (run + 1 > lim_num) stop(ERR_NUM_LONG, p);
                        else run++;
                    end else begin
                        put(REC_SPAN, ntok - 24'd1, TYP_NUMBER, {1'b0, nnum},
                            p - run, run, ERR_NONE);
                        mode = MD_AFTER;
                        after_value(c, p);
                    end
                end
                MD_SKIP: begin
                    if (eot) stop(ERR_BAD_END, p);
                    else if (run <= 1) begin
                        run = 0;
                        mode = MD_AFTER;
                    end else begin
                        run--;
                    end
                end
                MD_AFTER: after_value(c, p);
                MD_OBJ_NEXT: begin
                    if (!is_ws(c)) begin
                        if (c == "\"") start_key(p);
                        else stop(ERR_NO_KEY, p);
                    end
                end
                MD_END: begin
                    if (!is_ws(c)) begin
                        if (eot) begin
                            put(REC_DONE, ntok, 0, 0, p, 0, ERR_NONE);
                            mode = MD_DONE;
                        end else begin
                            stop(ERR_BAD_END, p);
                        end
                    end
                end
                default: ;
            endcase
            if (!eot) pos = p + 1;
            if (step_q.size() > 0) step_q[step_q.size() - 1].fin = 1;
            foreach (step_q[i]) due.push_back(step_q[i]);
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                         e, a);
                errors++;
            end
        endfunction

        // Compare one accepted record with the oldest one due.
        function void check(t_rec got, logic got_fin);
            token_rec_t x;
            if (due.size() == 0) begin
                $display("%0t: unexpected record, expected none, actual kind %0d",
                         $time, got.kind);
                errors++;
                return;
            end
            x = due.pop_front();
            records++;
            cmp("record_kind", x.r.kind, got.kind);
            cmp("token_index", x.r.index, got.index);
            cmp("token_type", x.r.ttype, got.ttype);
            cmp("value", x.r.value, got.value);
            cmp("text_start", x.r.start, got.start);
            cmp("text_chars", x.r.chars, got.chars);
            cmp("error_code", x.r.err, got.err);
            cmp("last", x.fin, got_fin);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its signals
    // ------------------------------------------------------------------------
    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic              i_cfg_index = 0;
    logic [7:0]        i_cfg_data = 0;
    logic              i_in_valid = 0;
    logic              o_in_stall;
    logic [7:0]        i_text_byte = 0;
    logic              i_end_of_text = 0;
    logic              o_out_valid;
    logic              i_out_stall = 0;
    logic [2:0]        o_record_kind;
    logic [TOKEN_BITS-1:0] o_token_index;
    logic [2:0]        o_token_type;
    logic [TOKEN_BITS:0] o_value;
    logic [31:0]       o_text_start;
    logic [31:0]       o_text_chars;
    logic [3:0]        o_error_code;
    logic              o_last;

    json_structural_tokenizer dut (.*);

    always #5 i_clk = ~i_clk;

    token_scoreboard tokens = new();
    text_item_t      text_q[$];
    int              cycles = 0;
    int              cfg_writes = 0;
    int              ending = 0;
    bit              hold_go = 0;
    bit              hold_done = 0;
    int              hold_left = 0;
    int              stall_left = 0;

    // Timeout and record monitor.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall)
            tokens.check(mk_rec(o_record_kind, o_token_index, o_token_type, o_value,
                                o_text_start, o_text_chars, o_error_code), o_last);
    end

    // Receiver stall: random bursts, quiet windows and one long hold.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 19);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1;
        end else if (hold_go && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1;
            i_out_stall <= 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1;
        end else if (cycles[9:8] == 2'd0 || r < 12) begin
            i_out_stall <= 0;
        end else begin
            stall_left <= (r < 18) ? $urandom_range(0, 2) : $urandom_range(5, 25);
            i_out_stall <= 1;
        end
    end

    // ------------------------------------------------------------------------
    // Document builder
    // ------------------------------------------------------------------------
    task automatic add(logic [7:0] b);
        text_item_t t;
        t = '{b: b, eot: 0, brk: 0, cidx: 0, cval: 0, hold: 0};
        text_q.push_back(t);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add(s[i]);
    endtask

    task automatic add_eot();
        text_item_t t;
        t = '{b: $urandom_range(0, 255), eot: 1, brk: 0, cidx: 0, cval: 0, hold: 0};
        text_q.push_back(t);
    endtask

    task automatic add_cfg(logic idx, logic [7:0] val);
        text_item_t t;
        t = '{b: 0, eot: 0, brk: 1, cidx: idx, cval: val, hold: 0};
        text_q.push_back(t);
    endtask

    task automatic add_ws();
        logic [7:0] ws[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) add(ws[$urandom_range(0, 3)]);
    endtask

    // Quoted text with arbitrary bytes; quotes and backslashes are escaped.
    task automatic add_quoted();
        logic [7:0] b;
        add("\"");
        repeat ($urandom_range(0, 5)) begin
            b = $urandom_range(0, 255);
            if (b == "\"" || b == "\\") add("\\");
            add(b);
        end
        add("\"");
    endtask

    task automatic add_number();
        string digits = "0123456789+-.eE";
        int n;
        n = $urandom_range(1, 8);
        add($urandom_range(0, 3) == 0 ? "-" : "0" + $urandom_range(0, 9));
        repeat (n - 1) add(digits[$urandom_range(0, 14)]);
    endtask

    // One random value; lvl is the parent depth the block will be at.
    task automatic add_value(int lvl);
        int k, n;
        k = $urandom_range(0, 9);
        if (k < 2 && lvl < 6 && text_q.size() < 190) begin
            add("{");
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if (i > 0) add(",");
                add_ws();
                add_quoted();
                add_ws();
                add(":");
                add_ws();
                if (lvl + 2 < 6) add_value(lvl + 2);
                else add_number();
                add_ws();
            end
            add("}");
        end else if (k < 4 && lvl < 6 && text_q.size() < 190) begin
            add("[");
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                if (i > 0) add(",");
                add_ws();
                add_value(lvl + 1);
                add_ws();
            end
            add("]");
        end else if (k < 6) begin
            add_quoted();
        end else if (k < 8) begin
            add_number();
        end else begin
            case ($urandom_range(0, 3))
                0: add_text("true");
                1: add_text("false");
                2: add_text("null");
                default: add_text("tQ#z");
            endcase
        end
    endtask

    task automatic build_text();
        // Directed opening: whitespace, escapes, every token type, empties.
        add_text(" \t\n\r[{\"a\\\"\\\\\":[true,-0,null,\"\",{}],\"k\":[]}");
        add(","); add("\""); add(8'h00); add(8'hFF); add("\"");
        add_cfg(CFG_DEPTH_LIMIT, 8'd255);
        add_cfg(CFG_MAX_NUMBER, 8'd63);
        add(",");
        text_q[text_q.size() - 1].hold = 1;
        add_text("false");
        while (text_q.size() < 200) begin
            if (text_q.size() > 110 && cfg_writes == 0) begin
                add_cfg(CFG_DEPTH_LIMIT, 8'd6);
                add_cfg(CFG_MAX_NUMBER, 8'd8);
                cfg_writes = 1;
            end
            add(",");
            add_ws();
            add_value(1);
        end
        cfg_writes = 0;
        ending = $urandom_range(0, 4);
        case (ending)
            0: begin
                add_text("] \n");
                add_eot();
                add_eot();
            end
            1: add_text("] x ");
            2: begin
                add_cfg(CFG_DEPTH_LIMIT, 8'd1);
                add_text(",[1]");
            end
            3: begin
                add_cfg(CFG_MAX_NUMBER, 8'd1);
                add_text(",12]");
            end
            default: begin
                add_text(",\"ab");
                add_eot();
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    task automatic drain();
        i_in_valid <= 0;
        while (tokens.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        tokens.set_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic send_text();
        int r, gap;
        foreach (text_q[i]) begin
            if (text_q[i].brk) begin
                drain();
                write_reg(text_q[i].cidx, text_q[i].cval);
                continue;
            end
            r = $urandom_range(0, 9);
            gap = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
            if (gap > 0) begin
                i_in_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1;
            i_text_byte <= text_q[i].b;
            i_end_of_text <= text_q[i].eot;
            do @(posedge i_clk); while (o_in_stall);
            tokens.note_input(text_q[i].b, text_q[i].eot);
            if (text_q[i].hold) hold_go <= 1;
        end
        i_in_valid <= 0;
    endtask

    initial begin
        build_text();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_text();
        drain();
        $display("tb: %0d text requests sent, %0d records checked, %0d register writes",
                 text_q.size(), tokens.records, cfg_writes);
        $display("tb: document ending variant %0d, final parse mode %s", ending,
                 tokens.mode.name());
        if (tokens.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/jst_pkg.sv
hw/rtl/jst_front.sv
hw/rtl/jst_queue.sv
hw/rtl/jst_back.sv
hw/rtl/json_structural_tokenizer.sv
bench/tb.sv
